[src/tlet_pkg.sv]
// Package for the timed LED event table: opcodes, status codes and the
// control structs passed between the sequencer and the slot map.
// No dependencies.
`default_nettype none

package tlet_pkg;

  // Item opcodes
  typedef enum logic [1:0] {
    OP_TICK   = 2'd0,
    OP_ADD    = 2'd1,
    OP_REMOVE = 2'd2,
    OP_QUERY  = 2'd3
  } tlet_op_t;

  // Result status codes
  localparam logic [2:0] ST_OK    = 3'd0;
  localparam logic [2:0] ST_FULL  = 3'd1;
  localparam logic [2:0] ST_NONE  = 3'd2;
  localparam logic [2:0] ST_RANGE = 3'd3;
  localparam logic [2:0] ST_EMPTY = 3'd4;

  // Width of a slot index as carried between modules (up to 256 slots)
  localparam int unsigned IDX_BITS = 8;

  // Slot map update request
  typedef struct packed {
    logic                set;
    logic                clr;
    logic [IDX_BITS-1:0] idx;
  } tlet_map_cmd_t;

  // Slot map occupancy flags
  typedef struct packed {
    logic any;
    logic full;
  } tlet_map_st_t;

endpackage

`default_nettype wire

[src/tlet_ram.sv]
// Generic single-write, single-read synchronous RAM with registered read.
// No dependencies.
`default_nettype none

module tlet_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16
) (
  input  wire                                  clk,
  input  wire                                  we,
  input  wire  [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  wire  [WIDTH-1:0]                     wdata,
  input  wire  [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                     rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

[src/tlet_slot_map.sv]
// Slot occupancy map: one valid flop per slot plus a fill count.
// Depends on tlet_pkg.
`default_nettype none

module tlet_slot_map
  import tlet_pkg::*;
#(
  parameter int unsigned NUM_SLOTS = 16
) (
  input  wire                                          clk,
  input  wire                                          rst,
  input  tlet_map_cmd_t                                cmd,
  input  wire  [(NUM_SLOTS > 1 ? $clog2(NUM_SLOTS) : 1)-1:0] rd_idx,
  output logic                                         rd_valid,
  output tlet_map_st_t                                 st
);

  localparam int unsigned IW = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;
  localparam int unsigned CW = $clog2(NUM_SLOTS + 1);

  logic [NUM_SLOTS-1:0] valid;
  logic [CW-1:0]        count;

  // Set and clear are never requested together
  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= '0;
      count <= '0;
    end else if (cmd.set) begin
      valid[cmd.idx[IW-1:0]] <= 1'b1;
      count <= count + CW'(1);
    end else if (cmd.clr) begin
      valid[cmd.idx[IW-1:0]] <= 1'b0;
      count <= count - CW'(1);
    end
  end

  assign rd_valid = valid[rd_idx];
  assign st.any   = (count != '0);
  assign st.full  = (count == CW'(NUM_SLOTS));

endmodule

`default_nettype wire

[src/timed_led_event_table.sv]
// Timed LED event table, top level: item sequencer, LED register and
// result register. Depends on tlet_pkg, tlet_ram and tlet_slot_map.
//
// Usage: one input channel (in_valid/in_ready) carries items with an opcode:
// tick (current time), add event, remove event or query. Every item gives
// exactly one result on the output channel (out_valid/out_ready): status,
// chosen slot, LED bits after the item and an any-events flag.
// Items are handled one at a time. A tick reads every slot from the event
// RAM in turn, one read per cycle, and applies each in-use entry whose time
// matches to the LED bits. An add walks the valid flops from slot 0 until
// it finds a free one; on a full table it goes straight to the done state,
// as do remove and query, where the result is loaded into the output register.
// The block is ready again in the cycle after its result is loaded into the
// output register, so a new item may be taken while a result still waits.
// If the receiver stalls with a result held, a finished item waits in the
// sequencer until the output register frees.
// Reset (rst, synchronous) empties the table through the valid flops, turns
// all LEDs off and drops out_valid; the RAM contents need no clearing.
`default_nettype none

module timed_led_event_table
  import tlet_pkg::*;
#(
  parameter int unsigned NUM_SLOTS  = 16,
  parameter int unsigned TIME_WIDTH = 32
) (
  input  wire         clk,
  input  wire         rst,
  input  wire         in_valid,
  output logic        in_ready,
  input  wire  [1:0]  opcode,
  input  wire  [31:0] now_time,
  input  wire         action,
  input  wire  [2:0]  led_number,
  input  wire  [31:0] event_time,
  input  wire  [7:0]  slot_index,
  output logic        out_valid,
  input  wire         out_ready,
  output logic [2:0]  status,
  output logic [3:0]  slot,
  output logic [7:0]  led_state,
  output logic        any_events
);

  localparam int unsigned IW  = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;
  localparam int unsigned SCW = $clog2(NUM_SLOTS + 1);
  localparam int unsigned SW  = (TIME_WIDTH < 32) ? TIME_WIDTH : 32;
  localparam int unsigned DW  = SW + 4;

  typedef enum logic [1:0] {
    S_IDLE,
    S_TICK,
    S_ADD,
    S_DONE
  } state_t;

  state_t        state;
  logic [SCW-1:0] scan;
  logic [IW-1:0]  scan_addr;
  logic           issuing;
  logic           rd_pend;
  logic [IW-1:0]  rd_q;
  logic [SW-1:0]  now_r;
  logic           act_r;
  logic [2:0]     led_r;
  logic [SW-1:0]  etime_r;
  logic [7:0]     led_bits;
  logic [2:0]     res_status;
  logic [3:0]     res_slot;

  logic           ram_we;
  logic [DW-1:0]  ram_wdata;
  logic [DW-1:0]  ram_rdata;

  tlet_map_cmd_t  map_cmd;
  tlet_map_st_t   map_st;
  logic [IW-1:0]  map_rd_idx;
  logic           map_rd_valid;

  logic           in_xfer;
  logic           out_free;
  logic           rem_in_range;
  logic           hit;

  assign in_ready  = (state == S_IDLE);
  assign in_xfer   = in_valid && in_ready;
  assign out_free  = !out_valid || out_ready;
  assign scan_addr = scan[IW-1:0];
  assign issuing   = (scan < SCW'(NUM_SLOTS));
  assign rem_in_range = ({1'b0, slot_index} < 9'(NUM_SLOTS));

  // Valid-flop read index follows whichever step needs it
  always_comb begin
    unique case (state)
      S_IDLE:  map_rd_idx = slot_index[IW-1:0];
      S_TICK:  map_rd_idx = rd_q;
      default: map_rd_idx = scan_addr;
    endcase
  end

  // Slot map updates: add claims a free slot, remove frees one on transfer
  always_comb begin
    map_cmd     = '0;
    map_cmd.idx = IDX_BITS'(scan_addr);
    if (state == S_ADD && !map_rd_valid) begin
      map_cmd.set = 1'b1;
    end else if (in_xfer && opcode == OP_REMOVE && map_st.any && rem_in_range &&
                 map_rd_valid) begin
      map_cmd.clr = 1'b1;
      map_cmd.idx = slot_index;
    end
  end

  // Event RAM write on a successful add
  assign ram_we    = map_cmd.set;
  assign ram_wdata = {act_r, led_r, etime_r};

  // A returned entry fires when it is in use and its time matches
  assign hit = rd_pend && map_rd_valid && (ram_rdata[SW-1:0] == now_r);

  tlet_ram #(
    .WIDTH (DW),
    .DEPTH (NUM_SLOTS)
  ) u_event_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (scan_addr),
    .wdata (ram_wdata),
    .raddr (scan_addr),
    .rdata (ram_rdata)
  );

  tlet_slot_map #(
    .NUM_SLOTS (NUM_SLOTS)
  ) u_slot_map (
    .clk      (clk),
    .rst      (rst),
    .cmd      (map_cmd),
    .rd_idx   (map_rd_idx),
    .rd_valid (map_rd_valid),
    .st       (map_st)
  );

  // Sequencer, LED register and result register
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      scan      <= '0;
      rd_pend   <= 1'b0;
      led_bits  <= '0;
      out_valid <= 1'b0;
    end else begin
      // A result loaded in S_DONE takes over the slot being drained
      if (out_valid && out_ready && state != S_DONE) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (in_xfer) begin
            now_r      <= now_time[SW-1:0];
            act_r      <= action;
            led_r      <= led_number;
            etime_r    <= event_time[SW-1:0];
            scan       <= '0;
            rd_pend    <= 1'b0;
            res_status <= ST_OK;
            res_slot   <= '0;
            unique case (tlet_op_t'(opcode))
              OP_TICK: state <= S_TICK;
              OP_ADD: begin
                if (map_st.full) begin
                  res_status <= ST_FULL;
                  state      <= S_DONE;
                end else begin
                  state <= S_ADD;
                end
              end
              OP_REMOVE: begin
                priority if (!map_st.any) res_status <= ST_NONE;
                else if (!rem_in_range)   res_status <= ST_RANGE;
                else if (!map_rd_valid)   res_status <= ST_EMPTY;
                else                      res_status <= ST_OK;
                state <= S_DONE;
              end
              OP_QUERY: state <= S_DONE;
            endcase
          end
        end
        S_TICK: begin
          // Issue one read a cycle, handle the entry read in the last cycle
          if (issuing) begin
            scan <= scan + SCW'(1);
          end
          rd_pend <= issuing;
          rd_q    <= scan_addr;
          if (hit) begin
            led_bits[ram_rdata[SW+2:SW]] <= ram_rdata[SW+3];
          end
          if (!issuing && !rd_pend) begin
            state <= S_DONE;
          end
        end
        S_ADD: begin
          if (!map_rd_valid) begin
            res_slot <= 4'(scan_addr);
            state    <= S_DONE;
          end else begin
            scan <= scan + SCW'(1);
          end
        end
        S_DONE: begin
          if (out_free) begin
            status     <= res_status;
            slot       <= res_slot;
            led_state  <= led_bits;
            any_events <= map_st.any;
            out_valid  <= 1'b1;
            state      <= S_IDLE;
          end
        end
      endcase
    end
  end

  // An add scan only starts with room in the table
  a_add_not_full: assert property (@(posedge clk) disable iff (rst)
    (state == S_ADD) |-> !map_st.full)
    else $error("add scan running on a full table");

  // A full report implies the table holds events
  a_full_has_events: assert property (@(posedge clk) disable iff (rst)
    (out_valid && status == ST_FULL) |-> any_events)
    else $error("table full reported with no events");

  // A remove on an empty table leaves it empty
  a_none_is_empty: assert property (@(posedge clk) disable iff (rst)
    (out_valid && status == ST_NONE) |-> !any_events)
    else $error("no-events status with events present");

  // Tick read returns only while the scan is live
  a_tick_pend: assert property (@(posedge clk) disable iff (rst)
    rd_pend |-> (state == S_TICK))
    else $error("RAM read pending outside a tick");

endmodule

`default_nettype wire
